// File: rtl/gmsa_pkg.sv
// ----------------------------------------------------------------------------
// gmsa_pkg
// Constants and types shared by the grid mesh surface area block.
// ----------------------------------------------------------------------------
package gmsa_pkg;

  localparam int unsigned CfgWidth  = 13;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned AreaWidth = 64;

  localparam logic [CfgWidth-1:0] GridColsRst = 13'd4096;

  // Point sequencer, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_DIFF = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_ROOT = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

// File: rtl/gmsa_point_if.sv
// ----------------------------------------------------------------------------
// gmsa_point_if
// Point item channel: valid/ready handshake and one grid point.
// ----------------------------------------------------------------------------
interface gmsa_point_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          point_finite;
  logic                          last_point;

  modport source (output valid, point_x, point_y, point_z, point_finite, last_point,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_finite, last_point,
                  output ready);
endinterface

// File: rtl/gmsa_area_if.sv
// ----------------------------------------------------------------------------
// gmsa_area_if
// Result item channel: valid/ready handshake and the summed area.
// ----------------------------------------------------------------------------
interface gmsa_area_if;
  logic                               valid;
  logic                               ready;
  logic [gmsa_pkg::AreaWidth-1:0]     area_total;
  logic                               area_saturated;

  modport source (output valid, area_total, area_saturated, input ready);
  modport sink   (input valid, area_total, area_saturated, output ready);
endinterface

// File: rtl/grid_mesh_surface_area_core.sv
// ----------------------------------------------------------------------------
// grid_mesh_surface_area_core
// Surface area of a triangulated point grid streamed in raster order.
// ----------------------------------------------------------------------------
// Points arrive on pt_i, one per item, grid_cols per row. The previous row
// sits in a line buffer RAM with a registered read. Each completed cell gives two
// triangles; each adds floor(sqrt(|cross|^2)/2) to a saturating Q48.16 sum.
// On the item flagged last_point the sum is emitted on area_o and cleared.
// cfg_we_i/cfg_wdata_i write grid_cols (0 acts as 1, large values clamp).
// One point is processed at a time. R = 2*COORD_WIDTH+3 is the bit count
// of the shared square root unit (R=51 at the default width). Sixteen steps
// of a shared multiplier build the cross product and its squared norm; the
// restoring root then takes one bit a cycle. A triangle with an invalid
// corner skips the arithmetic.
// Reset clears the sum, the left and upper-left neighbours, column position
// and the output valid flag; the line buffer is not cleared. The result is
// held in an output register; a new point is taken while it waits, but a
// further last point stalls until the receiver takes the pending result.
// ----------------------------------------------------------------------------
module grid_mesh_surface_area_core #(
  parameter int unsigned MAX_COLS    = 4096,
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gmsa_pkg::CfgWidth-1:0]   cfg_wdata_i,
  gmsa_point_if.sink                      pt_i,
  gmsa_area_if.source                     area_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CLW  = (AW + 1 > gmsa_pkg::CfgWidth) ? AW + 1 : gmsa_pkg::CfgWidth;
  localparam int unsigned HW   = W + 1;          // diff width, half of cross width
  localparam int unsigned OPW  = HW + 1;         // signed multiplier operand
  localparam int unsigned PW   = 2 * OPW;
  localparam int unsigned CW   = 2 * HW;         // cross magnitude
  localparam int unsigned SW   = 4 * HW + 2;     // squared norm
  localparam int unsigned RW   = SW / 2;         // root
  localparam int unsigned REMW = RW + 2;
  localparam int unsigned RCW  = $clog2(RW);
  localparam int unsigned RXW  = (RW > 66) ? RW : 66;
  localparam int unsigned AR   = gmsa_pkg::AreaWidth;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                ok;
  } point_t;

  gmsa_pkg::state_e state_q, state_d;

  logic [gmsa_pkg::CfgWidth-1:0] grid_cols_q;
  point_t  cur_q, left_q, upleft_q, above_q, rd_q;
  logic    last_q;
  logic [AW-1:0] col_q;
  logic    row_nz_q;
  logic    tri_q;
  logic [AR-1:0] sum_q;
  logic    clip_q;
  logic    out_valid_q;
  logic [AR-1:0] out_area_q;
  logic    out_sat_q;

  point_t mem [MAX_COLS];

  // triangle arithmetic
  logic signed [HW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic [3:0]           mstep_q;
  logic signed [PW-1:0] prod_q, tmp_q;
  logic [CW-1:0]        cx_q, cy_q, cz_q;
  logic [SW-1:0]        s_q;
  logic [REMW-1:0]      rem_q;
  logic [RW-1:0]        root_q;
  logic [RCW-1:0]       rcnt_q;

  point_t ta, tb, tc;
  logic signed [OPW-1:0] opa, opb;
  logic signed [PW-1:0]  prod_d;
  logic signed [PW:0]    crs, crs_mag;
  logic [CW-1:0]         cr_new;
  logic [SW-1:0]         sq_term;
  logic [REMW-1:0]       rem_sh, trial;
  logic [RXW-1:0]        root_x;
  logic [AR-1:0]         tri_area;
  logic                  tri_clip;
  logic [AR:0]           sum_add;
  logic [CLW-1:0]        cols_eff, col_nxt;
  logic                  accept, has_cell;
  point_t                in_pt;
  logic signed [W-1:0]   minus_one;

  assign minus_one = W'(-(1 <<< gmsa_pkg::FracBits));
  assign accept    = pt_i.valid & pt_i.ready;
  assign pt_i.ready = (state_q == gmsa_pkg::ST_IDLE);

  assign in_pt.x  = pt_i.point_x;
  assign in_pt.y  = pt_i.point_y;
  assign in_pt.z  = pt_i.point_z;
  assign in_pt.ok = pt_i.point_finite &
                    ~((pt_i.point_x == minus_one) & (pt_i.point_y == minus_one) &
                      (pt_i.point_z == minus_one));

  assign area_o.valid          = out_valid_q;
  assign area_o.area_total     = out_area_q;
  assign area_o.area_saturated = out_sat_q;

  always_comb begin
    cols_eff = CLW'(grid_cols_q);
    if (cols_eff == '0) begin
      cols_eff = CLW'(1);
    end else if (cols_eff > CLW'(MAX_COLS)) begin
      cols_eff = CLW'(MAX_COLS);
    end
    col_nxt = CLW'(col_q) + CLW'(1);
  end

  assign has_cell = row_nz_q & (col_q != '0);

  // triangle corners
  always_comb begin
    if (!tri_q) begin
      ta = upleft_q; tb = above_q; tc = left_q;
    end else begin
      ta = cur_q;    tb = left_q;  tc = above_q;
    end
  end

  // shared multiplier: six cross terms, then three squares in halves
  always_comb begin
    opa = '0;
    opb = '0;
    case (mstep_q)
      4'd0:  begin opa = OPW'(uy_q); opb = OPW'(vz_q); end
      4'd1:  begin opa = OPW'(uz_q); opb = OPW'(vy_q); end
      4'd2:  begin opa = OPW'(uz_q); opb = OPW'(vx_q); end
      4'd3:  begin opa = OPW'(ux_q); opb = OPW'(vz_q); end
      4'd4:  begin opa = OPW'(ux_q); opb = OPW'(vy_q); end
      4'd5:  begin opa = OPW'(uy_q); opb = OPW'(vx_q); end
      4'd6:  begin opa = {1'b0, cx_q[CW-1:HW]}; opb = {1'b0, cx_q[CW-1:HW]}; end
      4'd7:  begin opa = {1'b0, cx_q[CW-1:HW]}; opb = {1'b0, cx_q[HW-1:0]};  end
      4'd8:  begin opa = {1'b0, cx_q[HW-1:0]};  opb = {1'b0, cx_q[HW-1:0]};  end
      4'd9:  begin opa = {1'b0, cy_q[CW-1:HW]}; opb = {1'b0, cy_q[CW-1:HW]}; end
      4'd10: begin opa = {1'b0, cy_q[CW-1:HW]}; opb = {1'b0, cy_q[HW-1:0]};  end
      4'd11: begin opa = {1'b0, cy_q[HW-1:0]};  opb = {1'b0, cy_q[HW-1:0]};  end
      4'd12: begin opa = {1'b0, cz_q[CW-1:HW]}; opb = {1'b0, cz_q[CW-1:HW]}; end
      4'd13: begin opa = {1'b0, cz_q[CW-1:HW]}; opb = {1'b0, cz_q[HW-1:0]};  end
      4'd14: begin opa = {1'b0, cz_q[HW-1:0]};  opb = {1'b0, cz_q[HW-1:0]};  end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_d  = opa * opb;
  assign crs     = (PW+1)'(tmp_q) - (PW+1)'(prod_q);
  assign crs_mag = crs[PW] ? -crs : crs;
  assign cr_new  = crs_mag[CW-1:0];

  // weight of the product consumed this cycle (step mstep_q - 1)
  always_comb begin
    case (mstep_q)
      4'd7, 4'd10, 4'd13: sq_term = SW'(prod_q[CW-1:0]) << (2 * HW);
      4'd8, 4'd11, 4'd14: sq_term = SW'(prod_q[CW-1:0]) << (HW + 1);
      default:            sq_term = SW'(prod_q[CW-1:0]);
    endcase
  end

  assign rem_sh = {rem_q[REMW-3:0], s_q[SW-1:SW-2]};
  assign trial  = {root_q, 2'b01};

  assign root_x   = RXW'(root_q);
  assign tri_clip = |root_x[RXW-1:AR+1];
  assign tri_area = tri_clip ? '1 : root_x[AR:1];
  assign sum_add  = {1'b0, sum_q} + {1'b0, tri_area};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gmsa_pkg::ST_IDLE: if (accept) state_d = gmsa_pkg::ST_READ;
      gmsa_pkg::ST_READ: state_d = has_cell ? gmsa_pkg::ST_DIFF : gmsa_pkg::ST_DONE;
      gmsa_pkg::ST_DIFF: begin
        if (ta.ok & tb.ok & tc.ok) begin
          state_d = gmsa_pkg::ST_MUL;
        end else begin
          state_d = tri_q ? gmsa_pkg::ST_DONE : gmsa_pkg::ST_DIFF;
        end
      end
      gmsa_pkg::ST_MUL:  if (mstep_q == 4'd15) state_d = gmsa_pkg::ST_ROOT;
      gmsa_pkg::ST_ROOT: if (rcnt_q == RCW'(RW - 1)) state_d = gmsa_pkg::ST_ACC;
      gmsa_pkg::ST_ACC:  state_d = tri_q ? gmsa_pkg::ST_DONE : gmsa_pkg::ST_DIFF;
      gmsa_pkg::ST_DONE: if (!(last_q & out_valid_q & ~area_o.ready)) begin
        state_d = gmsa_pkg::ST_IDLE;
      end
      default: state_d = gmsa_pkg::ST_IDLE;
    endcase
  end

  // line buffer: read at the column on accept, written back in the read state
  always_ff @(posedge clk_i) begin
    if (state_q == gmsa_pkg::ST_READ) begin
      mem[col_q] <= cur_q;
    end
    rd_q <= mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmsa_pkg::ST_IDLE;
      grid_cols_q <= gmsa_pkg::GridColsRst;
      left_q      <= '0;
      upleft_q    <= '0;
      col_q       <= '0;
      row_nz_q    <= 1'b0;
      tri_q       <= 1'b0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mstep_q     <= '0;
      rcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) grid_cols_q <= cfg_wdata_i;
      if (state_q == gmsa_pkg::ST_DONE && state_d == gmsa_pkg::ST_IDLE && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q & area_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        gmsa_pkg::ST_IDLE: begin
          tri_q <= 1'b0;
        end
        gmsa_pkg::ST_DIFF: begin
          mstep_q <= '0;
          rcnt_q  <= '0;
          if (!(ta.ok & tb.ok & tc.ok)) tri_q <= 1'b1;
        end
        gmsa_pkg::ST_MUL:  mstep_q <= mstep_q + 4'd1;
        gmsa_pkg::ST_ROOT: rcnt_q  <= rcnt_q + RCW'(1);
        gmsa_pkg::ST_ACC: begin
          tri_q <= 1'b1;
          if (sum_add[AR]) begin
            sum_q  <= '1;
          end else begin
            sum_q  <= sum_add[AR-1:0];
          end
          if (sum_add[AR] | tri_clip) clip_q <= 1'b1;
        end
        gmsa_pkg::ST_DONE: begin
          if (state_d == gmsa_pkg::ST_IDLE) begin
            if (last_q) begin
              left_q      <= '0;
              upleft_q    <= '0;
              col_q       <= '0;
              row_nz_q    <= 1'b0;
              sum_q       <= '0;
              clip_q      <= 1'b0;
            end else begin
              left_q   <= cur_q;
              upleft_q <= above_q;
              if (col_nxt >= cols_eff) begin
                col_q    <= '0;
                row_nz_q <= 1'b1;
              end else begin
                col_q    <= col_nxt[AW-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= in_pt;
      last_q <= pt_i.last_point;
    end
    if (state_q == gmsa_pkg::ST_READ) above_q <= rd_q;
    if (state_q == gmsa_pkg::ST_DONE && state_d == gmsa_pkg::ST_IDLE && last_q) begin
      out_area_q <= sum_q;
      out_sat_q  <= clip_q;
    end
    if (state_q == gmsa_pkg::ST_DIFF) begin
      ux_q <= HW'(tb.x) - HW'(ta.x);
      uy_q <= HW'(tb.y) - HW'(ta.y);
      uz_q <= HW'(tb.z) - HW'(ta.z);
      vx_q <= HW'(tc.x) - HW'(ta.x);
      vy_q <= HW'(tc.y) - HW'(ta.y);
      vz_q <= HW'(tc.z) - HW'(ta.z);
      s_q  <= '0;
    end
    if (state_q == gmsa_pkg::ST_MUL) begin
      prod_q <= prod_d;
      case (mstep_q)
        4'd1, 4'd3, 4'd5: tmp_q <= prod_q;
        4'd2:             cx_q  <= cr_new;
        4'd4:             cy_q  <= cr_new;
        4'd6:             cz_q  <= cr_new;
        4'd0:             ;
        default:          s_q   <= s_q + sq_term;
      endcase
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == gmsa_pkg::ST_ROOT) begin
      s_q <= s_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: sim/gmsa_area_checker.sv
// ----------------------------------------------------------------------------
// gmsa_area_checker
// Watches the point and area channels and the grid_cols write port, predicts
// the summed triangle area of each grid and compares every area item with it.
// ----------------------------------------------------------------------------
module gmsa_area_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gmsa_pkg::CfgWidth-1:0] cfg_wdata_i,
  gmsa_point_if                         pt,
  gmsa_area_if                          ar,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCols = 4096;

  typedef struct {
    longint x;
    longint y;
    longint z;
    bit     ok;
  } grid_pt_t;

  typedef struct {
    logic [gmsa_pkg::AreaWidth-1:0] total;
    logic                           sat;
  } area_exp_t;

  area_exp_t   area_queue[$];
  longint      line_x[MaxCols];
  longint      line_y[MaxCols];
  longint      line_z[MaxCols];
  bit          line_ok[MaxCols];
  grid_pt_t    left_pt, upleft_pt;
  int unsigned col_idx;
  bit          past_first_row;
  logic [63:0] sum_acc;
  bit          sum_sat;
  logic [12:0] cols_reg;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = area_queue.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic logic [127:0] cross_sq(longint a, longint b, longint c, longint d);
    longint p;
    logic [63:0] m;
    p = a * b - c * d;
    m = (p < 0) ? -p : p;
    return {64'b0, m} * {64'b0, m};
  endfunction

  function automatic logic [63:0] tri_area(grid_pt_t a, grid_pt_t b, grid_pt_t c);
    longint ux, uy, uz, vx, vy, vz;
    logic [127:0] norm_sq, cand_sq;
    logic [63:0]  root, cand;
    if (!a.ok || !b.ok || !c.ok) return 64'd0;
    ux = b.x - a.x; uy = b.y - a.y; uz = b.z - a.z;
    vx = c.x - a.x; vy = c.y - a.y; vz = c.z - a.z;
    norm_sq = cross_sq(uy, vz, uz, vy) + cross_sq(uz, vx, ux, vz) + cross_sq(ux, vy, uy, vx);
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      cand    = root | (64'd1 << k);
      cand_sq = {64'b0, cand} * {64'b0, cand};
      if (cand_sq <= norm_sq) root = cand;
    end
    return root >> 1;
  endfunction

  function automatic void add_area(logic [63:0] a);
    logic [64:0] t;
    t = {1'b0, sum_acc} + {1'b0, a};
    if (t[64]) begin
      sum_acc = '1;
      sum_sat = 1'b1;
    end else begin
      sum_acc = t[63:0];
    end
  endfunction

  function automatic void clear_grid();
    left_pt        = '{0, 0, 0, 1'b0};
    upleft_pt      = '{0, 0, 0, 1'b0};
    col_idx        = 0;
    past_first_row = 1'b0;
    sum_acc        = '0;
    sum_sat        = 1'b0;
  endfunction

  function automatic void predict_point();
    int unsigned cols, c;
    grid_pt_t    cur, above;
    longint      minus_one;
    cols = cols_reg;
    if (cols < 1) cols = 1;
    if (cols > MaxCols) cols = MaxCols;
    minus_one = -(longint'(1) << gmsa_pkg::FracBits);
    cur.x  = longint'(pt.point_x);
    cur.y  = longint'(pt.point_y);
    cur.z  = longint'(pt.point_z);
    cur.ok = pt.point_finite && !(cur.x == minus_one && cur.y == minus_one && cur.z == minus_one);
    c = col_idx % MaxCols;
    above = '{line_x[c], line_y[c], line_z[c], line_ok[c]};
    if (past_first_row && c > 0) begin
      add_area(tri_area(upleft_pt, above, left_pt));
      add_area(tri_area(cur, left_pt, above));
    end
    upleft_pt  = above;
    left_pt    = cur;
    line_x[c]  = cur.x;
    line_y[c]  = cur.y;
    line_z[c]  = cur.z;
    line_ok[c] = cur.ok;
    if (c + 1 >= cols) begin
      col_idx        = 0;
      past_first_row = 1'b1;
    end else begin
      col_idx = c + 1;
    end
    if (pt.last_point) begin
      area_queue.push_back('{sum_acc, sum_sat});
      clear_grid();
    end
  endfunction

  initial begin
    fails    = 0;
    cols_reg = gmsa_pkg::GridColsRst;
    clear_grid();
  end

  always @(posedge clk_i) begin
    area_exp_t e;
    if (rst_ni) begin
      if (ar.valid && ar.ready) begin
        if (area_queue.size() == 0) begin
          report("unexpected area item", ar.area_total, 64'd0);
        end else begin
          e = area_queue.pop_front();
          if (ar.area_total !== e.total) report("area_total", ar.area_total, e.total);
          if (ar.area_saturated !== e.sat) begin
            report("area_saturated", 64'(ar.area_saturated), 64'(e.sat));
          end
        end
      end
      if (pt.valid && pt.ready) predict_point();
      if (cfg_we_i) cols_reg = cfg_wdata_i;
    end
  end

endmodule

// File: sim/grid_mesh_surface_area_core_tb.sv
// ----------------------------------------------------------------------------
// grid_mesh_surface_area_core_tb
// Streams point grids of several row widths with random gaps and receiver
// stalls, including one long stall; the checker predicts and compares areas.
// ----------------------------------------------------------------------------
module grid_mesh_surface_area_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  IdleCycles = 320;
  localparam int  TotalItems = 560;
  localparam real RunLimit   = 40_000_000.0;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [gmsa_pkg::CfgWidth-1:0] cfg_wdata_i = '0;
  int                            fail_count, pending;
  int                            sent = 0;
  bit                            stim_done = 1'b0;

  gmsa_point_if #(.COORD_WIDTH(24)) pt_bus ();
  gmsa_area_if                      area_bus ();

  always #4 clk_i = ~clk_i;

  grid_mesh_surface_area_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pt_i       (pt_bus),
    .area_o     (area_bus)
  );

  gmsa_area_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pt          (pt_bus),
    .ar          (area_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off while points keep coming
  initial begin
    int  n;
    bit  held;
    area_bus.ready = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 25) begin
        held = 1'b1;
        area_bus.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      if (sent > 400 && sent < 440) begin
        area_bus.ready <= 1'b1;
      end else begin
        n = gap_len();
        if (n == 0) begin
          area_bus.ready <= 1'b1;
        end else begin
          area_bus.ready <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_point(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z,
                            input logic fin, input logic last);
    int g;
    g = gap_len();
    if (g > 0 || !pt_bus.valid) begin
      pt_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
      if (g == 0 && !pt_bus.valid) @(posedge clk_i);
    end
    pt_bus.valid        <= 1'b1;
    pt_bus.point_x      <= x;
    pt_bus.point_y      <= y;
    pt_bus.point_z      <= z;
    pt_bus.point_finite <= fin;
    pt_bus.last_point   <= last;
    do @(posedge clk_i); while (!(pt_bus.valid && pt_bus.ready));
    sent++;
  endtask

  task automatic settle();
    pt_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic set_cols(input logic [12:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  task automatic rand_point(input logic last);
    logic [23:0] x, y, z;
    if ($urandom_range(0, 19) == 0) begin
      x = -24'sd256; y = -24'sd256; z = -24'sd256;
    end else begin
      x = rand_coord(); y = rand_coord(); z = rand_coord();
    end
    send_point(x, y, z, $urandom_range(0, 15) != 0, last);
  endtask

  // one grid of n points, flagged last on its final point
  task automatic rand_grid(input int n);
    for (int i = 0; i < n; i++) rand_point(i == n - 1);
  endtask

  initial begin
    logic [23:0] hi, lo, m1;
    int          cols, pick, n;
    int          col_set[9];
    pt_bus.valid        = 1'b0;
    pt_bus.point_x      = '0;
    pt_bus.point_y      = '0;
    pt_bus.point_z      = '0;
    pt_bus.point_finite = 1'b0;
    pt_bus.last_point   = 1'b0;
    col_set = '{1, 2, 3, 4, 5, 7, 0, 4096, 8191};
    hi = 24'h7fffff;
    lo = 24'h800000;
    m1 = -24'sd256;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3-wide grids with extreme, invalid and minus-one points
    set_cols(13'd3);
    send_point(lo, lo, lo, 1'b1, 1'b0);
    send_point(hi, lo, 24'd0, 1'b1, 1'b0);
    send_point(lo, hi, hi, 1'b1, 1'b0);
    send_point(hi, hi, lo, 1'b1, 1'b0);
    send_point(lo, 24'd0, hi, 1'b1, 1'b0);
    send_point(hi, hi, hi, 1'b1, 1'b0);
    send_point(m1, m1, m1, 1'b1, 1'b0);
    send_point(24'd512, 24'd0, 24'd0, 1'b0, 1'b0);
    send_point(24'd0, 24'd256, 24'd512, 1'b1, 1'b1);
    send_point(lo, hi, lo, 1'b1, 1'b0);
    send_point(hi, lo, hi, 1'b1, 1'b0);
    send_point(lo, lo, hi, 1'b1, 1'b0);
    send_point(hi, hi, lo, 1'b1, 1'b0);
    send_point(lo, hi, hi, 1'b1, 1'b1);
    send_point(24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
    settle();

    // single-column grids: most points end a grid, stalls during hold-off
    set_cols(13'd1);
    for (int i = 0; i < 40; i++) rand_point($urandom_range(0, 3) != 0);
    rand_point(1'b1);
    settle();

    while (sent < TotalItems) begin
      pick = $urandom_range(0, 8);
      cols = col_set[pick];
      set_cols(13'(cols));
      for (int g = 0; g < 4 && sent < TotalItems; g++) begin
        if (cols == 0 || cols >= 4096) n = $urandom_range(1, 6);
        else n = cols * $urandom_range(1, 5) - $urandom_range(0, cols - 1);
        rand_grid(n);
      end
      settle();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) begin
      $display("** grid_mesh_surface_area_core: PASSED **");
    end else begin
      $display("** grid_mesh_surface_area_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("timeout, %0d area items outstanding", pending);
    $display("** grid_mesh_surface_area_core: FAILED **");
    $finish;
  end

endmodule
